/* hdl/rlrm_pkg.sv */
// Shared constants, register indexes, command codes and the cell control
// struct for the run-length ratio matcher. No dependencies.
package rlrm_pkg;

	// Default sizes handed to the top-level parameters
	localparam int RUN_DEPTH_DEF   = 16;
	localparam int COUNT_WIDTH_DEF = 16;

	// Fixed field widths
	localparam int CMD_W      = 2;
	localparam int VALUE_W    = 32;
	localparam int AMOUNT_W   = 16;
	localparam int LATEST_W   = 16;
	localparam int RATIO_W    = 4;
	localparam int PLEN_W     = 5;
	localparam int PATTERN_W  = 64;
	localparam int SCALE_SH   = 4;    // match scale of 16
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	// Register reset values
	localparam logic [PLEN_W-1:0]    PLEN_RESET  = 5'd5;
	localparam logic [PATTERN_W-1:0] RATIO_RESET = 64'h0000_0000_0001_1311;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_PATTERN  = 1'b1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NEW_RUN = 2'd2;

	// Control shared by every cell of the run chain
	typedef struct packed {
		logic open;   // shift counts one place back, head starts from zero
		logic add;    // add the cell's amount input to its count
		logic load;   // copy count into the scan register
		logic step;   // shift scan registers one place towards the head
	} cell_ctrl_t;

endpackage

/* hdl/rlrm_cell.sv */
// One cell of the run chain: a saturating run counter and a scan register.
// Depends on rlrm_pkg.
module rlrm_cell #(
	parameter int COUNT_WIDTH = rlrm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rlrm_pkg::cell_ctrl_t           ctrl,
	input  logic [COUNT_WIDTH-1:0]         shift_in,
	input  logic [rlrm_pkg::AMOUNT_W-1:0]  add_in,
	input  logic [COUNT_WIDTH-1:0]         scan_in,
	output logic [COUNT_WIDTH-1:0]         count,
	output logic [COUNT_WIDTH-1:0]         scan
);
	import rlrm_pkg::*;

	localparam int SUM_W = ((COUNT_WIDTH > AMOUNT_W) ? COUNT_WIDTH : AMOUNT_W) + 1;

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] scan_q;
	logic [COUNT_WIDTH-1:0] base;
	logic [SUM_W-1:0]       sum;
	logic [COUNT_WIDTH-1:0] sat_sum;

	// Saturating add onto the held or the shifted-in count
	always_comb begin
		base    = ctrl.open ? shift_in : count_q;
		sum     = SUM_W'(base) + SUM_W'(add_in);
		sat_sum = (sum > SUM_W'({COUNT_WIDTH{1'b1}})) ? {COUNT_WIDTH{1'b1}}
		                                              : sum[COUNT_WIDTH-1:0];
	end

	// Hold the run count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.open || ctrl.add) begin
			count_q <= sat_sum;
		end
	end

	// Scan register: load a snapshot, then advance towards the head
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			scan_q <= count_q;
		end else if (ctrl.step) begin
			scan_q <= scan_in;
		end
	end

	assign count = count_q;
	assign scan  = scan_q;

endmodule

/* hdl/rlrm_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on rlrm_pkg only for the import convention.
module rlrm_div #(
	parameter int DIVIDEND_W = 28,
	parameter int DIVISOR_W  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);
	import rlrm_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// Trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		ge    = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(DIVIDEND_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift quotient bits in, keep the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hdl/run_length_ratio_matcher.sv */
// Top level of the run-length ratio matcher: command decode, run chain,
// match sequencer and output register. Depends on rlrm_pkg, rlrm_cell, rlrm_div.
//
// Usage:
//  Input stream (s_*): one transfer per item; s_tuser carries the command
//  (push value, add amount, start new run), s_tdata the value and amount.
//  Output stream (m_*): one transfer per item with new_run, matched and the
//  low 16 bits of the current run count.
//  Configuration: cfg_we writes cfg_wdata into the register at cfg_index
//  (0 pattern length, 1 ratio pattern); write only while the block is idle.
//  Sequence: the chain updates at the transfer, a snapshot loads it into the
//  scan registers, a scan adds the window into the sums, the serial divider
//  forms the scaled average, a second snapshot and scan check each run, and
//  the result is registered. A window with an empty run or no ratio skips
//  the divider. One item is in work at a time; the next item is taken only
//  once the block is back in idle.
//  A stalled receiver holds the result in the output register; the next item
//  is still taken and waits for that slot only once its test is finished.
//  Reset clears every run count, the previous value, the registers to their
//  defaults and the output valid.
module run_length_ratio_matcher #(
	parameter int RUN_DEPTH   = rlrm_pkg::RUN_DEPTH_DEF,
	parameter int COUNT_WIDTH = rlrm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rlrm_pkg::S_TDATA_W-1:0]   s_tdata,   // value[31:0], amount[47:32]
	input  logic [rlrm_pkg::CMD_W-1:0]       s_tuser,   // command[1:0]
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rlrm_pkg::M_TDATA_W-1:0]   m_tdata,   // new_run[0], matched[1],
	                                                    // latest_count[17:2], zero pad
	// configuration
	input  logic                             cfg_we,
	input  logic [rlrm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rlrm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import rlrm_pkg::*;

	localparam int NUM_W      = $clog2(RUN_DEPTH + 1);
	localparam int LOG_DEPTH  = $clog2(RUN_DEPTH);
	localparam int CSUM_W     = COUNT_WIDTH + LOG_DEPTH;
	localparam int RSUM_W     = RATIO_W + LOG_DEPTH;
	localparam int DIVIDEND_W = CSUM_W + SCALE_SH;
	localparam int PROD_W     = DIVIDEND_W + RATIO_W;
	localparam int CMP_W      = PROD_W + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_SUM, S_DIV, S_LOAD2, S_CHECK, S_DONE
	} state_t;

	state_t                  state_q;
	logic [PLEN_W-1:0]       plen_q;
	logic [PATTERN_W-1:0]    ratio_q;
	logic [VALUE_W-1:0]      prev_q;
	logic [NUM_W-1:0]        n_q;
	logic [NUM_W-1:0]        b_q;
	logic [CSUM_W-1:0]       csum_q;
	logic [RSUM_W-1:0]       rsum_q;
	logic                    zero_q;
	logic [DIVIDEND_W-1:0]   avg_q;
	logic [DIVIDEND_W-1:0]   err_q;
	logic                    fail_q;
	logic                    new_run_q;
	logic [LATEST_W-1:0]     latest_q;
	logic                    div_start_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;

	logic                    accept;
	logic [CMD_W-1:0]        cmd;
	logic [VALUE_W-1:0]      value;
	logic [AMOUNT_W-1:0]     amount;
	logic                    differ;
	logic [AMOUNT_W-1:0]     head_add;
	cell_ctrl_t              ctrl;
	logic [COUNT_WIDTH-1:0]  cnt_w  [RUN_DEPTH];
	logic [COUNT_WIDTH-1:0]  scan_w [RUN_DEPTH];
	logic [NUM_W-1:0]        n_clamp;
	logic [NUM_W-1:0]        ni_full;
	logic [RATIO_W-1:0]      nib_sel;
	logic [RATIO_W-1:0]      nib;
	logic [COUNT_WIDTH-1:0]  scan0;
	logic [CMP_W-1:0]        c16;
	logic [CMP_W-1:0]        prod;
	logic                    bound_fail;
	logic                    sums_ok;
	logic                    out_free;
	logic                    div_done;
	logic [DIVIDEND_W-1:0]   quotient;

	// Decode the incoming command
	always_comb begin
		accept    = s_tvalid && s_tready;
		cmd       = s_tuser;
		value     = s_tdata[VALUE_W-1:0];
		amount    = s_tdata[VALUE_W +: AMOUNT_W];
		differ    = value != prev_q;
		head_add  = (cmd == CMD_PUSH) ? AMOUNT_W'(1) : amount;
		ctrl.open = accept && (((cmd == CMD_PUSH) && differ) || (cmd == CMD_NEW_RUN));
		ctrl.add  = accept && ((cmd == CMD_PUSH) || (cmd == CMD_ADD) || (cmd == CMD_NEW_RUN));
		ctrl.load = (state_q == S_LOAD) || (state_q == S_LOAD2);
		ctrl.step = (state_q == S_SUM) || (state_q == S_CHECK);
	end

	// Run chain: cell 0 is the current run, cell k the run k places back
	for (genvar k = 0; k < RUN_DEPTH; k++) begin : g_cell
		logic [COUNT_WIDTH-1:0] shift_in;
		logic [COUNT_WIDTH-1:0] scan_in;
		logic [AMOUNT_W-1:0]    add_in;
		if (k == 0) begin : g_head
			assign shift_in = '0;
			assign add_in   = head_add;
		end else begin : g_body
			assign shift_in = cnt_w[k-1];
			assign add_in   = '0;
		end
		if (k == RUN_DEPTH - 1) begin : g_tail
			assign scan_in = '0;
		end else begin : g_inner
			assign scan_in = scan_w[k+1];
		end
		rlrm_cell #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.shift_in (shift_in),
			.add_in   (add_in),
			.scan_in  (scan_in),
			.count    (cnt_w[k]),
			.scan     (scan_w[k])
		);
	end

	// Serial divider for the average unit
	rlrm_div #(
		.DIVIDEND_W(DIVIDEND_W),
		.DIVISOR_W (RSUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend ({csum_q, {SCALE_SH{1'b0}}}),
		.divisor  (rsum_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Ratio of the run at the scan head, tolerance test against it
	always_comb begin
		n_clamp    = (plen_q > PLEN_W'(RUN_DEPTH)) ? NUM_W'(RUN_DEPTH) : NUM_W'(plen_q);
		ni_full    = n_q - NUM_W'(1) - b_q;
		nib_sel    = RATIO_W'(ni_full);
		nib        = ratio_q[{nib_sel, 2'b00} +: RATIO_W];
		scan0      = scan_w[0];
		c16        = CMP_W'({scan0, {SCALE_SH{1'b0}}});
		prod       = CMP_W'(nib) * CMP_W'(avg_q);
		bound_fail = ((c16 + CMP_W'(err_q)) < prod) || (c16 > (prod + CMP_W'(err_q)));
		sums_ok    = (rsum_q != '0) && (csum_q != '0) && !zero_q;
		out_free   = !m_tvalid_q || m_tready;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= PLEN_RESET;
			ratio_q <= RATIO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LENGTH: plen_q  <= cfg_wdata[PLEN_W-1:0];
				REG_RATIO_PATTERN:  ratio_q <= cfg_wdata[PATTERN_W-1:0];
				default: ;
			endcase
		end
	end

	// Match sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_q      <= '0;
			div_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// start the divider once the sums are complete and usable
			div_start_q <= (state_q == S_SUM) && (b_q == n_q) && sums_ok;
			// drop the result once taken, unless a new one replaces it
			if (m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						new_run_q <= ctrl.open;
						if ((cmd == CMD_PUSH) && differ) begin
							prev_q <= value;
						end
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					n_q      <= n_clamp;
					b_q      <= '0;
					csum_q   <= '0;
					rsum_q   <= '0;
					zero_q   <= 1'b0;
					latest_q <= LATEST_W'(cnt_w[0]);
					state_q  <= S_SUM;
				end
				S_SUM: begin
					if (b_q != n_q) begin
						if (nib != '0) begin
							csum_q <= csum_q + CSUM_W'(scan0);
							rsum_q <= rsum_q + RSUM_W'(nib);
						end
						if (scan0 == '0) begin
							zero_q <= 1'b1;
						end
						b_q <= b_q + NUM_W'(1);
					end else if (sums_ok) begin
						state_q <= S_DIV;
					end else begin
						fail_q  <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						avg_q   <= quotient;
						err_q   <= quotient >> 1;
						state_q <= S_LOAD2;
					end
				end
				S_LOAD2: begin
					b_q     <= '0;
					fail_q  <= 1'b0;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (b_q != n_q) begin
						if ((nib != '0) && bound_fail) begin
							fail_q <= 1'b1;
						end
						b_q <= b_q + NUM_W'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_TDATA_W'({latest_q, !fail_q, new_run_q});
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// One item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// A result appears only from the finishing step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("result raised outside the finishing step");

	// A finished result waits while the output slot is stalled
	a_wait_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && m_tvalid && !m_tready |=> (state_q == S_DONE) && $stable(m_tdata))
		else $error("pending result overwritten");

endmodule

/* sim/rlrm_checker.sv */
// Scoreboard for the run-length ratio matcher: keeps its own run ring, applies
// every input transfer to it and compares each output transfer in order.
// Depends on rlrm_pkg only.
module rlrm_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [rlrm_pkg::S_TDATA_W-1:0]  s_tdata,   // value[31:0], amount[47:32]
	input  logic [rlrm_pkg::CMD_W-1:0]      s_tuser,   // command[1:0]
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [rlrm_pkg::M_TDATA_W-1:0]  m_tdata,   // new_run[0], matched[1],
	                                                   // latest_count[17:2], zero pad
	input  logic                            cfg_we,
	input  logic [rlrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rlrm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              fail_count,
	output int                              pending,
	output int                              results_checked,
	output int                              matches_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import rlrm_pkg::*;

	localparam int              DEPTH     = RUN_DEPTH_DEF;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;
	localparam longint unsigned SCALE     = 64'd1 << SCALE_SH;

	// One result as it leaves the block, lowest field last
	typedef struct packed {
		logic [LATEST_W-1:0] latest;
		logic                matched;
		logic                new_run;
	} run_report_t;

	logic [COUNT_WIDTH_DEF-1:0] run_len [DEPTH];
	int                         head;
	logic [VALUE_W-1:0]         prev_value;
	logic [PLEN_W-1:0]          pat_len;
	logic [PATTERN_W-1:0]       pattern;
	run_report_t                expected_reports [$];
	int                         errors;
	int                         checked;
	int                         match_total;

	function automatic longint unsigned run_behind(input int back);
		int pos;
		pos = (head + DEPTH - (back % DEPTH)) % DEPTH;
		return 64'(run_len[pos]);
	endfunction

	function automatic void grow_head(input longint unsigned n);
		longint unsigned sum;
		sum = 64'(run_len[head]) + n;
		run_len[head] = (sum > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH_DEF-1:0]
		                                  : sum[COUNT_WIDTH_DEF-1:0];
	endfunction

	function automatic void open_run();
		head = (head + 1) % DEPTH;
		run_len[head] = '0;
	endfunction

	// Ratio test over the newest runs, oldest first, at a scale of 16
	function automatic bit ratio_fits();
		int              n;
		int              i;
		longint unsigned sum_count;
		longint unsigned sum_ratio;
		longint unsigned avg;
		longint unsigned tol;
		longint unsigned r;
		longint unsigned c;
		longint unsigned centre;
		n = int'(pat_len);
		if (n > DEPTH) n = DEPTH;
		if (n > 16) n = 16;
		sum_count = 0;
		sum_ratio = 0;
		for (i = 0; i < n; i++) begin
			r = 64'(pattern[4*i +: RATIO_W]);
			if (r != 0) begin
				sum_ratio += r;
				sum_count += run_behind(n - i - 1);
			end
		end
		if (sum_ratio == 0 || sum_count == 0) return 1'b0;
		avg = (sum_count * SCALE) / sum_ratio;
		tol = avg / 2;
		for (i = 0; i < n; i++) begin
			r = 64'(pattern[4*i +: RATIO_W]);
			c = run_behind(n - i - 1) * SCALE;
			// wildcard runs must still be non-empty
			if (c == 0) return 1'b0;
			if (r != 0) begin
				centre = r * avg;
				if (c + tol < centre || c > centre + tol) return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Apply one command to the ring and work out the result it yields
	function automatic run_report_t step_runs(input logic [CMD_W-1:0] cmd,
	                                          input logic [VALUE_W-1:0] value,
	                                          input logic [AMOUNT_W-1:0] amount);
		run_report_t rep;
		rep.new_run = 1'b0;
		case (cmd)
			CMD_PUSH: begin
				if (value != prev_value) begin
					prev_value = value;
					open_run();
					rep.new_run = 1'b1;
				end
				grow_head(1);
			end
			CMD_ADD: grow_head(64'(amount));
			CMD_NEW_RUN: begin
				open_run();
				grow_head(64'(amount));
				rep.new_run = 1'b1;
			end
			default: ;  // spare code: ring left as it is
		endcase
		rep.matched = ratio_fits();
		rep.latest  = run_len[head][LATEST_W-1:0];
		return rep;
	endfunction

	task automatic report(input string field, input longint unsigned seen,
	                      input longint unsigned wanted);
		errors++;
		$display("[%0t] mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
		         $realtime, field, checked, seen, wanted);
	endtask

	// Watch configuration, output and input transfers at every edge
	always @(posedge clk or negedge arst_n) begin : watch
		run_report_t got;
		run_report_t want;
		int          i;
		if (!arst_n) begin
			for (i = 0; i < DEPTH; i++) run_len[i] = '0;
			head        = 2 % DEPTH;
			prev_value  = '0;
			pat_len     = PLEN_RESET;
			pattern     = RATIO_RESET;
			expected_reports.delete();
			errors      = 0;
			checked     = 0;
			match_total = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN_LENGTH: pat_len = cfg_wdata[PLEN_W-1:0];
					REG_RATIO_PATTERN:  pattern = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(run_report_t)-1:0];
				if (expected_reports.size() == 0) begin
					report("unexpected result transfer", 64'(m_tdata), 0);
				end else begin
					want = expected_reports.pop_front();
					if (got.new_run !== want.new_run)
						report("new_run", 64'(got.new_run), 64'(want.new_run));
					if (got.matched !== want.matched)
						report("matched", 64'(got.matched), 64'(want.matched));
					if (got.latest !== want.latest)
						report("latest_count", 64'(got.latest), 64'(want.latest));
					if (want.matched) match_total++;
				end
				checked++;
			end
			if (s_tvalid && s_tready)
				expected_reports.push_back(step_runs(s_tuser, s_tdata[VALUE_W-1:0],
				                                     s_tdata[VALUE_W +: AMOUNT_W]));
		end
		fail_count      <= errors;
		pending         <= expected_reports.size();
		results_checked <= checked;
		matches_seen    <= match_total;
	end

endmodule

/* sim/tb_run_length_ratio_matcher.sv */
// Top-level testbench of the run-length ratio matcher: clock, reset, stimulus
// and verdict. Depends on rlrm_pkg, rlrm_checker and run_length_ratio_matcher.
module tb_run_length_ratio_matcher;
	timeunit 1ns;
	timeprecision 1ps;
	import rlrm_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;  // unused code, changes nothing
	localparam int     ITEM_TARGET  = 1950;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     DRAIN_CYCLES = 80;
	// bound on the whole run, far above what the items need
	localparam int     CYCLE_LIMIT  = 1500000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic [CMD_W-1:0]      s_tuser   = '0;
	logic                  m_tready  = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tready;
	logic                  m_tvalid;
	logic [M_TDATA_W-1:0]  m_tdata;

	int fail_count;
	int pending;
	int results_checked;
	int matches_seen;

	bit                   idle_on      = 1'b1;
	int                   hold_orders  = 0;
	int                   hold_seen    = 0;
	int                   hold_left    = 0;
	int                   cycles       = 0;
	int                   items_sent   = 0;
	int                   settings     = 1;
	int                   cur_len      = int'(PLEN_RESET);
	logic [PATTERN_W-1:0] cur_pattern  = RATIO_RESET;
	logic [VALUE_W-1:0]   recent_push  = '0;

	run_length_ratio_matcher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	rlrm_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.matches_seen    (matches_seen)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("FAIL run_length_ratio_matcher");
			$finish;
		end
	end

	// Receiver: random stalls while idling is on, plus a long hold-off when one is ordered
	always @(posedge clk) begin
		if (hold_seen != hold_orders) begin
			hold_seen = hold_orders;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (idle_on) begin
			m_tready <= ($urandom_range(0, 99) >= 14);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one item and hold it until the transfer
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
	                         input int amount);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 14) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {amount[AMOUNT_W-1:0], value};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (cmd == CMD_PUSH) recent_push = value;
		items_sent++;
	endtask

	// Stop offering until every outstanding result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram both registers once the block is idle
	task automatic set_config(input int len, input logic [PATTERN_W-1:0] pat);
		logic [CFG_DATA_W-1:0] len_word;
		drain();
		// junk above the length field must be dropped
		len_word = {$urandom, $urandom};
		len_word[PLEN_W-1:0] = PLEN_W'(len);
		write_reg(REG_PATTERN_LENGTH, len_word);
		write_reg(REG_RATIO_PATTERN, pat);
		cur_len     = len;
		cur_pattern = pat;
		settings++;
	endtask

	function automatic logic [VALUE_W-1:0] fresh_value();
		logic [VALUE_W-1:0] v;
		v = $urandom;
		if (v == recent_push) v = ~v;
		return v;
	endfunction

	function automatic logic [PATTERN_W-1:0] random_pattern();
		logic [PATTERN_W-1:0] p;
		int                   i;
		for (i = 0; i < 16; i++) begin
			if ($urandom_range(0, 3) == 0)      p[4*i +: RATIO_W] = '0;
			else if ($urandom_range(0, 1) == 0) p[4*i +: RATIO_W] = RATIO_W'($urandom_range(1, 4));
			else                                p[4*i +: RATIO_W] = RATIO_W'($urandom_range(1, 15));
		end
		return p;
	endfunction

	function automatic int random_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 31);
		return $urandom_range(1, 16);
	endfunction

	// One stray item of any kind, biased towards the field extremes
	task automatic send_noise();
		int                 kind;
		int                 amt;
		logic [VALUE_W-1:0] v;
		kind = $urandom_range(0, 19);
		if ($urandom_range(0, 7) == 0) amt = $urandom_range(0, 1) ? 65535 : 0;
		else amt = $urandom_range(0, 65535);
		v = $urandom_range(0, 1) ? recent_push : $urandom;
		if (kind < 8)       send_item(CMD_PUSH, v, amt);
		else if (kind < 13) send_item(CMD_ADD, v, amt);
		else if (kind < 19) send_item(CMD_NEW_RUN, v, amt);
		else                send_item(CMD_SPARE, v, amt);
	endtask

	// Build runs that follow the current pattern, some near the tolerance edge
	task automatic send_sequence();
		int                 n;
		int                 i;
		int                 u;
		int                 sum_r;
		int                 target;
		int                 part;
		bit                 by_push;
		logic [RATIO_W-1:0] r;
		logic [VALUE_W-1:0] v;
		n = (cur_len > 16) ? 16 : cur_len;
		if (n == 0) begin
			send_noise();
			return;
		end
		sum_r = 0;
		for (i = 0; i < n; i++) begin
			r = cur_pattern[4*i +: RATIO_W];
			sum_r += (r == 0) ? 2 : int'(r);
		end
		by_push = (sum_r <= 48) && ($urandom_range(0, 2) == 0);
		if (by_push)                     u = 1;
		else if ($urandom_range(0, 1))   u = $urandom_range(1, 20);
		else                             u = $urandom_range(1, 4369);
		for (i = 0; i < n; i++) begin
			r = cur_pattern[4*i +: RATIO_W];
			target = (r == 0) ? int'($urandom_range(1, 3 * u)) : int'(r) * u;
			if ($urandom_range(0, 3) == 0)
				target += int'($urandom_range(0, u + 1)) - (u + 1) / 2;
			if (target > 65535) target = 65535;
			if (target < 0) target = 0;
			if (by_push) begin
				if (target < 1) target = 1;
				v = fresh_value();
				send_item(CMD_PUSH, v, $urandom_range(0, 65535));
				repeat (target - 1) send_item(CMD_PUSH, v, $urandom_range(0, 65535));
			end else if (target > 1 && $urandom_range(0, 2) == 0) begin
				part = $urandom_range(0, target);
				send_item(CMD_NEW_RUN, $urandom, part);
				send_item(CMD_ADD, $urandom, target - part);
			end else begin
				send_item(CMD_NEW_RUN, $urandom, target);
			end
		end
	endtask

	task automatic run_phase(input int quota);
		int stop;
		stop = items_sent + quota;
		while (items_sent < stop) begin
			if ($urandom_range(0, 9) < 7) send_sequence();
			else repeat ($urandom_range(1, 4)) send_noise();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, saturation, zero run, spare code
		send_item(CMD_PUSH, '0, 0);                 // same as reset value: no new run
		send_item(CMD_PUSH, '1, 65535);
		send_item(CMD_PUSH, '1, 0);
		send_item(CMD_ADD, '0, 0);
		send_item(CMD_ADD, '0, 65535);              // saturate the count
		send_item(CMD_ADD, '1, 65535);
		send_item(CMD_NEW_RUN, '0, 0);              // empty run
		send_item(CMD_SPARE, 32'hA5A5_5A5A, 16'h5A5A);
		send_item(CMD_NEW_RUN, '1, 65535);
		// exact 1:1:3:1:1 against the reset pattern
		send_item(CMD_NEW_RUN, $urandom, 2);
		send_item(CMD_NEW_RUN, $urandom, 2);
		send_item(CMD_NEW_RUN, $urandom, 6);
		send_item(CMD_NEW_RUN, $urandom, 2);
		send_item(CMD_NEW_RUN, $urandom, 2);
		send_item(CMD_SPARE, '1, 65535);            // must report the match unchanged
		send_item(CMD_PUSH, 32'h5555_5555, 0);
		send_item(CMD_PUSH, 32'hAAAA_AAAA, 16'hFFFF);
		// zero pattern length never matches
		set_config(0, RATIO_RESET);
		send_item(CMD_NEW_RUN, $urandom, 5);
		send_item(CMD_ADD, $urandom, 1);
		// over-long length clamps to the ring depth
		set_config(31, '1);
		repeat (3) send_item(CMD_NEW_RUN, $urandom, 7);
		// single wildcard run never matches: the window holds no ratio
		set_config(1, '0);
		send_item(CMD_NEW_RUN, $urandom, 0);
		send_item(CMD_ADD, $urandom, 3);

		// Reset settings again, with a long receiver hold-off part way through
		set_config(int'(PLEN_RESET), RATIO_RESET);
		run_phase(120);
		hold_orders <= hold_orders + 1;
		repeat (30) send_noise();
		run_phase(80);
		set_config(1, 64'h1);
		run_phase(100);
		set_config(16, '1);
		run_phase(150);
		set_config(0, random_pattern());
		run_phase(40);
		set_config($urandom_range(17, 31), random_pattern());
		run_phase(150);
		set_config($urandom_range(1, 16), '0);
		run_phase(50);
		// a stretch with no idling on either side
		idle_on <= 1'b0;
		set_config($urandom_range(1, 16), random_pattern());
		run_phase(150);
		drain();
		idle_on <= 1'b1;
		while (items_sent < ITEM_TARGET) begin
			set_config(random_len(), random_pattern());
			run_phase(120);
		end
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items across %0d register settings; %0d results checked, %0d matched.",
		         items_sent, settings, results_checked, matches_seen);
		$display("Covered saturation, empty and wildcard runs, clamped and zero lengths, stalls.");
		if (fail_count == 0 && pending == 0) begin
			$display("PASS run_length_ratio_matcher");
		end else begin
			$display("%0d mismatches, %0d results missing", fail_count, pending);
			$display("FAIL run_length_ratio_matcher");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/rlrm_pkg.sv
hdl/rlrm_cell.sv
hdl/rlrm_div.sv
hdl/run_length_ratio_matcher.sv
sim/rlrm_checker.sv
sim/tb_run_length_ratio_matcher.sv
